/* hw/rtl/cfc_pkg.sv */
// Package for the cascaded FIR convolution: types, constants and register codes.
`timescale 1ns / 1ps

package cfc_pkg;

    // Default build parameters
    localparam int FIRST_TAPS  = 5;
    localparam int SECOND_TAPS = 7;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 8;

    // Largest tap count any stage may have, and the tap index it needs
    localparam int MAX_TAPS     = 8;
    localparam int TAP_IDX_BITS = $clog2(MAX_TAPS);

    // Fixed field widths of the words on the ports
    localparam int IN_SAMPLE_BITS = 16;
    localparam int OUT_BITS       = 38;
    localparam int CFG_IDX_BITS   = 8;
    localparam int CFG_DATA_BITS  = 64;
    localparam int TAPS0_BITS     = 40;
    localparam int TAPS1_BITS     = 56;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_TAPS  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_SECOND_TAPS = CFG_IDX_BITS'(1);

    // Register reset values: {1,2,3,2,1} and {1,0,0,0,0,0,1}
    localparam logic [TAPS0_BITS-1:0] TAPS0_RESET = 40'h01_0203_0201;
    localparam logic [TAPS1_BITS-1:0] TAPS1_RESET = 56'h01_0000_0000_0001;

    typedef struct packed {
        logic signed [IN_SAMPLE_BITS-1:0] sample;
        logic                             is_final;
    } t_in_word;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] filtered;
        logic                       end_of_run;
    } t_out_word;

    // Controller to datapath commands
    typedef struct packed {
        logic                    load;       // shift a new value into the first window
        logic                    load_zero;  // that value is a flush zero
        logic                    acc_clr;    // clear the accumulator
        logic                    mac_en;     // multiply-accumulate one tap
        logic                    mac_second; // the tap belongs to the second stage
        logic [TAP_IDX_BITS-1:0] tap;        // tap index of this step
        logic                    shift2;     // push first stage result into second window
        logic                    write;      // load the output register
        logic                    last;       // output word ends the run
        logic                    clear;      // clear both windows
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free; // output register can take a word this cycle
    } t_dp_stat;

endpackage

/* hw/rtl/cascaded_fir_convolution.sv */
// Top level of the cascaded FIR convolution: two FIR stages in cascade with tail flush.
//
//  channel   direction  handshake                     word
//  in        input      i_in_valid / o_in_ready       t_in_word  {sample, is_final}
//  out       output     o_out_valid / i_out_ready     t_out_word {filtered, end_of_run}
//  cfg       input      i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// One shared multiplier steps through the taps, so a sample goes from accept through the
// first-stage taps, the second-window shift and the second-stage taps to the output write;
// the next sample is taken only after that write, with the sequencer back at idle.
// Each flush step after a final sample runs the same steps, with a zero as its input.
// Reset is synchronous, active low; it restores the taps and clears both windows.
// A stalled output register holds the sequencer at its write step; o_cfg_ready is always high.
`timescale 1ns / 1ps

module cascaded_fir_convolution
    import cfc_pkg::*;
#(
    parameter int FIRST_TAPS  = cfc_pkg::FIRST_TAPS,
    parameter int SECOND_TAPS = cfc_pkg::SECOND_TAPS,
    parameter int SAMPLE_BITS = cfc_pkg::SAMPLE_BITS,
    parameter int COEF_BITS   = cfc_pkg::COEF_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in_word                 i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out_word                o_out_data,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    cfc_ctrl #(
        .FIRST_TAPS  (FIRST_TAPS),
        .SECOND_TAPS (SECOND_TAPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_is_final (i_in_data.is_final),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cfc_datapath #(
        .FIRST_TAPS  (FIRST_TAPS),
        .SECOND_TAPS (SECOND_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

/* hw/rtl/cfc_ctrl.sv */
// Sequencer for the cascaded FIR convolution: tap stepping, flush count and handshakes.
`timescale 1ns / 1ps

module cfc_ctrl
    import cfc_pkg::*;
#(
    parameter int FIRST_TAPS  = cfc_pkg::FIRST_TAPS,
    parameter int SECOND_TAPS = cfc_pkg::SECOND_TAPS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_is_final,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam int FLUSH  = FIRST_TAPS + SECOND_TAPS - 2;
    localparam int LEFT_W = (FLUSH > 0) ? $clog2(FLUSH + 1) : 1;
    localparam logic [TAP_IDX_BITS-1:0] LAST1 = TAP_IDX_BITS'(FIRST_TAPS - 1);
    localparam logic [TAP_IDX_BITS-1:0] LAST2 = TAP_IDX_BITS'(SECOND_TAPS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC1,
        S_SHIFT2,
        S_MAC2,
        S_WRITE
    } t_state;

    t_state                  r_state, n_state;
    logic [TAP_IDX_BITS-1:0] r_k, n_k;
    logic                    r_fin, n_fin;
    logic [LEFT_W-1:0]       r_left, n_left;

    logic accept;
    logic done_run;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign done_run   = r_fin && (r_left == '0);

    // Command decode and next state
    always_comb begin
        o_cmd      = '0;
        o_cmd.tap  = r_k;
        o_cmd.last = done_run;
        n_state    = r_state;
        n_k        = r_k;
        n_fin      = r_fin;
        n_left     = r_left;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.acc_clr = 1'b1;
                    n_fin         = i_is_final;
                    n_left        = LEFT_W'(FLUSH);
                    n_k           = '0;
                    n_state       = S_MAC1;
                end
            end
            S_MAC1: begin
                o_cmd.mac_en = 1'b1;
                if (r_k == LAST1) begin
                    n_state = S_SHIFT2;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_SHIFT2: begin
                o_cmd.shift2  = 1'b1;
                o_cmd.acc_clr = 1'b1;
                n_k           = '0;
                n_state       = S_MAC2;
            end
            S_MAC2: begin
                o_cmd.mac_en     = 1'b1;
                o_cmd.mac_second = 1'b1;
                if (r_k == LAST2) begin
                    n_state = S_WRITE;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_WRITE: begin
                if (i_stat.out_free) begin
                    o_cmd.write = 1'b1;
                    if (r_fin && !done_run) begin
                        // next flush step: push a zero
                        o_cmd.load      = 1'b1;
                        o_cmd.load_zero = 1'b1;
                        o_cmd.acc_clr   = 1'b1;
                        n_left          = r_left - 1'b1;
                        n_k             = '0;
                        n_state         = S_MAC1;
                    end else begin
                        o_cmd.clear = done_run;
                        n_fin       = 1'b0;
                        n_state     = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_fin   <= 1'b0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_fin   <= n_fin;
            r_left  <= n_left;
        end
    end

endmodule

/* hw/rtl/cfc_datapath.sv */
// Datapath for the cascaded FIR convolution: tap registers, windows, shared MAC, output.
`timescale 1ns / 1ps

module cfc_datapath
    import cfc_pkg::*;
#(
    parameter int FIRST_TAPS  = cfc_pkg::FIRST_TAPS,
    parameter int SECOND_TAPS = cfc_pkg::SECOND_TAPS,
    parameter int SAMPLE_BITS = cfc_pkg::SAMPLE_BITS,
    parameter int COEF_BITS   = cfc_pkg::COEF_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  t_in_word                 i_in_data,
    input  t_dp_cmd                  i_cmd,
    output t_dp_stat                 o_stat,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out_word                o_out_data
);

    localparam int Y1_BITS   = SAMPLE_BITS + COEF_BITS + $clog2(FIRST_TAPS);
    localparam int ACC_BITS  = Y1_BITS + COEF_BITS + $clog2(SECOND_TAPS);
    localparam int PROD_BITS = Y1_BITS + COEF_BITS;
    localparam int K1_W      = (FIRST_TAPS > 1) ? $clog2(FIRST_TAPS) : 1;
    localparam int K2_W      = (SECOND_TAPS > 1) ? $clog2(SECOND_TAPS) : 1;

    logic [TAPS0_BITS-1:0] r_taps0;
    logic [TAPS1_BITS-1:0] r_taps1;

    logic signed [SAMPLE_BITS-1:0] r_w1 [FIRST_TAPS];
    logic signed [Y1_BITS-1:0]     r_w2 [SECOND_TAPS];
    logic signed [ACC_BITS-1:0]    r_acc;

    logic      r_out_valid;
    t_out_word r_out;

    logic [CFG_DATA_BITS-1:0]      taps0_ext, taps1_ext;
    logic signed [COEF_BITS-1:0]   c1 [FIRST_TAPS];
    logic signed [COEF_BITS-1:0]   c2 [SECOND_TAPS];
    logic signed [SAMPLE_BITS-1:0] x_in;
    logic signed [Y1_BITS-1:0]     op_a;
    logic signed [COEF_BITS-1:0]   op_c;
    logic signed [PROD_BITS-1:0]   prod;
    logic                          out_free;

    // Coefficient lanes, tap zero in the lowest lane; lanes past the register read zero
    assign taps0_ext = CFG_DATA_BITS'(r_taps0);
    assign taps1_ext = CFG_DATA_BITS'(r_taps1);

    always_comb begin
        for (int k = 0; k < FIRST_TAPS; k++) begin
            c1[k] = taps0_ext[k*COEF_BITS +: COEF_BITS];
        end
        for (int k = 0; k < SECOND_TAPS; k++) begin
            c2[k] = taps1_ext[k*COEF_BITS +: COEF_BITS];
        end
    end

    // New first stage input: sample field taken from its low bits, or a flush zero
    assign x_in = i_cmd.load_zero ? '0
                                  : SAMPLE_BITS'($unsigned(i_in_data.sample));

    // Shared multiplier operands
    always_comb begin
        if (i_cmd.mac_second) begin
            op_a = r_w2[i_cmd.tap[K2_W-1:0]];
            op_c = c2[i_cmd.tap[K2_W-1:0]];
        end else begin
            op_a = Y1_BITS'(r_w1[i_cmd.tap[K1_W-1:0]]);
            op_c = c1[i_cmd.tap[K1_W-1:0]];
        end
    end

    assign prod     = op_a * op_c;
    assign out_free = !r_out_valid || i_out_ready;

    assign o_stat.out_free = out_free;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps0 <= TAPS0_RESET;
            r_taps1 <= TAPS1_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_FIRST_TAPS) begin
                r_taps0 <= i_cfg_data[TAPS0_BITS-1:0];
            end else if (i_cfg_index == CFG_SECOND_TAPS) begin
                r_taps1 <= i_cfg_data[TAPS1_BITS-1:0];
            end
        end
    end

    // Delay windows: entry zero is the newest value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int k = 0; k < FIRST_TAPS; k++) begin
                r_w1[k] <= '0;
            end
            for (int k = 0; k < SECOND_TAPS; k++) begin
                r_w2[k] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_w1[0] <= x_in;
                for (int k = 1; k < FIRST_TAPS; k++) begin
                    r_w1[k] <= r_w1[k-1];
                end
            end
            if (i_cmd.shift2) begin
                r_w2[0] <= r_acc[Y1_BITS-1:0];
                for (int k = 1; k < SECOND_TAPS; k++) begin
                    r_w2[k] <= r_w2[k-1];
                end
            end
        end
    end

    // Accumulator
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.mac_en) begin
            r_acc <= r_acc + ACC_BITS'(prod);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.write) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_out.filtered   <= OUT_BITS'(r_acc);
            r_out.end_of_run <= i_cmd.last;
        end
    end

endmodule

/* sim/tb_cascaded_fir_convolution.sv */
// Self-checking testbench for the cascaded FIR convolution: directed table, then random sequences.
`timescale 1ns / 1ps

module tb_cascaded_fir_convolution;
    import cfc_pkg::*;

    // Width of a first-stage result held in the second window
    localparam int STAGE1_BITS      = 27;
    localparam int FLUSH_LEN        = (FIRST_TAPS - 1) + (SECOND_TAPS - 1);
    localparam int SETTLE_CYCLES    = 2 * (FIRST_TAPS + SECOND_TAPS + 3);
    localparam int LONG_STALL       = 400;
    localparam int RANDOM_PER_PHASE = 116;
    localparam longint TIMEOUT_NS   = 64'd2_000_000;

    // Register indexes that decode to nothing
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_LOW  = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_HIGH = CFG_IDX_BITS'(255);

    typedef enum logic [1:0] {
        ROW_SAMPLE,
        ROW_CONFIG
    } t_row_kind;

    typedef struct {
        t_row_kind                  kind;
        logic [CFG_IDX_BITS-1:0]    index;
        logic [CFG_DATA_BITS-1:0]   data;
        logic signed [IN_SAMPLE_BITS-1:0] sample;
        logic                       is_final;
        bit                         has_typed;
        logic signed [OUT_BITS-1:0] typed;
    } t_stim_row;

    logic                     i_clk;
    logic                     i_rst_n   = 1'b0;
    logic                     in_valid  = 1'b0;
    t_in_word                 in_word   = '0;
    logic                     out_ready = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
    logic                     o_in_ready;
    logic                     o_out_valid;
    t_out_word                o_out_data;
    logic                     o_cfg_ready;

    cascaded_fir_convolution uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Predictor state: tap registers and both delay windows
    logic [TAPS0_BITS-1:0]             taps_first  = TAPS0_RESET;
    logic [TAPS1_BITS-1:0]             taps_second = TAPS1_RESET;
    logic signed [IN_SAMPLE_BITS-1:0]  first_line [FIRST_TAPS-1];
    logic signed [STAGE1_BITS-1:0]     second_line [SECOND_TAPS-1];

    t_out_word  pending_outputs[$];
    t_stim_row  directed_rows[$];
    int         mismatch_count = 0;
    int         send_idle_pct  = 0;
    int         recv_idle_pct  = 0;
    int         stall_requests = 0;
    int         stalls_served  = 0;
    int         stall_left     = 0;
    int         sender_idle_by_phase [3] = '{9, 86, 0};
    int         receiver_idle_by_phase [3] = '{86, 9, 0};

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        foreach (first_line[i]) first_line[i] = '0;
        foreach (second_line[i]) second_line[i] = '0;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Signed coefficient of lane k in a packed tap register
    function automatic longint tap_coef(input logic [CFG_DATA_BITS-1:0] packed_taps,
                                        input int k);
        logic signed [COEF_BITS-1:0] c;
        c = packed_taps[k*COEF_BITS +: COEF_BITS];
        return longint'(c);
    endfunction

    // Push one value through both stages, return the second-stage output
    task automatic advance_cascade(input logic signed [IN_SAMPLE_BITS-1:0] x,
                                   output logic signed [OUT_BITS-1:0] y);
        longint acc1;
        longint acc2;
        logic signed [STAGE1_BITS-1:0] y1;
        acc1 = tap_coef(CFG_DATA_BITS'(taps_first), 0) * longint'(x);
        for (int k = 1; k < FIRST_TAPS; k++)
            acc1 += tap_coef(CFG_DATA_BITS'(taps_first), k) * longint'(first_line[k-1]);
        for (int k = FIRST_TAPS - 2; k > 0; k--)
            first_line[k] = first_line[k-1];
        first_line[0] = x;
        y1 = acc1[STAGE1_BITS-1:0];
        acc2 = tap_coef(CFG_DATA_BITS'(taps_second), 0) * longint'(y1);
        for (int k = 1; k < SECOND_TAPS; k++)
            acc2 += tap_coef(CFG_DATA_BITS'(taps_second), k) * longint'(second_line[k-1]);
        for (int k = SECOND_TAPS - 2; k > 0; k--)
            second_line[k] = second_line[k-1];
        second_line[0] = y1;
        y = acc2[OUT_BITS-1:0];
    endtask

    // Expected output words of one accepted sample, flush tail included
    task automatic predict_convolution(input t_in_word w, input bit has_typed,
                                       input logic signed [OUT_BITS-1:0] typed);
        t_out_word r;
        logic signed [OUT_BITS-1:0] y;
        advance_cascade(w.sample, y);
        r.filtered   = has_typed ? typed : y;
        r.end_of_run = w.is_final && (FLUSH_LEN == 0);
        pending_outputs.push_back(r);
        if (w.is_final) begin
            for (int i = 0; i < FLUSH_LEN; i++) begin
                advance_cascade('0, y);
                r.filtered   = y;
                r.end_of_run = (i == FLUSH_LEN - 1);
                pending_outputs.push_back(r);
            end
            foreach (first_line[i]) first_line[i] = '0;
            foreach (second_line[i]) second_line[i] = '0;
        end
    endtask

    // Offer one input word, with random idle cycles ahead of it
    task automatic send_sample(input logic signed [IN_SAMPLE_BITS-1:0] sample,
                               input logic is_final, input bit has_typed,
                               input logic signed [OUT_BITS-1:0] typed);
        t_in_word w;
        w.sample   = sample;
        w.is_final = is_final;
        cfg_valid <= 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        predict_convolution(w, has_typed, typed);
    endtask

    // Register write; valid stays up so back-to-back writes need no gap
    task automatic write_register(input logic [CFG_IDX_BITS-1:0] index,
                                  input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            CFG_FIRST_TAPS:  taps_first  = data[TAPS0_BITS-1:0];
            CFG_SECOND_TAPS: taps_second = data[TAPS1_BITS-1:0];
            default: ;
        endcase
    endtask

    // Wait until every expected word is out, then let the sequencer settle
    task automatic wait_for_drain();
        in_valid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random sequences, each closed by a final sample
    task automatic run_sequences(input int item_count, input bit drain_midway);
        int sent;
        int len;
        logic signed [IN_SAMPLE_BITS-1:0] s;
        sent = 0;
        while (sent < item_count) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(60, 25) : $urandom_range(24, 1);
            if (len > item_count - sent) len = item_count - sent;
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(7) == 0)
                    s = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                else
                    s = 16'($urandom);
                if (drain_midway && sent == item_count / 2) wait_for_drain();
                send_sample(s, i == len - 1, 1'b0, '0);
                sent++;
            end
        end
    endtask

    function automatic t_stim_row sample_row(input logic signed [IN_SAMPLE_BITS-1:0] sample,
                                             input logic is_final, input bit has_typed,
                                             input logic signed [OUT_BITS-1:0] typed);
        t_stim_row r;
        r.kind      = ROW_SAMPLE;
        r.index     = '0;
        r.data      = '0;
        r.sample    = sample;
        r.is_final  = is_final;
        r.has_typed = has_typed;
        r.typed     = typed;
        return r;
    endfunction

    function automatic t_stim_row config_row(input logic [CFG_IDX_BITS-1:0] index,
                                             input logic [CFG_DATA_BITS-1:0] data);
        t_stim_row r;
        r = sample_row('0, 1'b0, 1'b0, '0);
        r.kind  = ROW_CONFIG;
        r.index = index;
        r.data  = data;
        return r;
    endfunction

    // Output side: check accepted words, then pick next ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (pending_outputs.size() == 0) begin
                    report_mismatch($sformatf("unexpected word filtered=%0d end_of_run=%0b",
                                              o_out_data.filtered, o_out_data.end_of_run));
                end else begin
                    if (o_out_data.filtered !== pending_outputs[0].filtered)
                        report_mismatch($sformatf("filtered got %0d want %0d",
                                                  o_out_data.filtered,
                                                  pending_outputs[0].filtered));
                    if (o_out_data.end_of_run !== pending_outputs[0].end_of_run)
                        report_mismatch($sformatf("end_of_run got %0b want %0b",
                                                  o_out_data.end_of_run,
                                                  pending_outputs[0].end_of_run));
                    void'(pending_outputs.pop_front());
                end
            end
            // long hold-off on request, random idling otherwise
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (stall_requests != stalls_served) begin
                stalls_served++;
                stall_left = LONG_STALL;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        // default taps: a lone sample after a clear passes straight through
        directed_rows.push_back(sample_row(16'sh7FFF, 1'b0, 1'b1, 38'sd32767));
        directed_rows.push_back(sample_row(16'sh8000, 1'b0, 1'b0, '0));
        directed_rows.push_back(sample_row(16'sd0, 1'b0, 1'b0, '0));
        directed_rows.push_back(sample_row(16'sd1, 1'b0, 1'b0, '0));
        directed_rows.push_back(sample_row(-16'sd1, 1'b1, 1'b0, '0));
        directed_rows.push_back(sample_row(16'sh8000, 1'b0, 1'b1, -38'sd32768));
        for (int i = 0; i < 4; i++)
            directed_rows.push_back(sample_row(16'sh8000, 1'b0, 1'b0, '0));
        directed_rows.push_back(sample_row(16'sh8000, 1'b1, 1'b0, '0));
        // one-sample sequence
        directed_rows.push_back(sample_row(16'sd12345, 1'b1, 1'b1, 38'sd12345));
        // most negative taps, junk above the used lanes, writes to unused indexes
        directed_rows.push_back(config_row(CFG_FIRST_TAPS, 64'hFFFF_FF80_8080_8080));
        directed_rows.push_back(config_row(CFG_SECOND_TAPS, 64'hFF80_8080_8080_8080));
        directed_rows.push_back(config_row(CFG_UNUSED_LOW, '1));
        directed_rows.push_back(config_row(CFG_UNUSED_HIGH, '0));
        directed_rows.push_back(sample_row(16'sh8000, 1'b0, 1'b1, -38'sd536870912));
        for (int i = 0; i < 4; i++)
            directed_rows.push_back(sample_row(16'sh8000, 1'b0, 1'b0, '0));
        directed_rows.push_back(sample_row(16'sh8000, 1'b1, 1'b0, '0));
        // most positive taps
        directed_rows.push_back(config_row(CFG_FIRST_TAPS, 64'h7F_7F7F_7F7F));
        directed_rows.push_back(config_row(CFG_SECOND_TAPS, 64'h7F_7F7F_7F7F_7F7F));
        directed_rows.push_back(sample_row(16'sh7FFF, 1'b0, 1'b1, 38'sd528498943));
        directed_rows.push_back(sample_row(16'sh8000, 1'b0, 1'b0, '0));
        directed_rows.push_back(sample_row(16'sh7FFF, 1'b1, 1'b0, '0));
        // zero first stage silences everything
        directed_rows.push_back(config_row(CFG_FIRST_TAPS, '0));
        directed_rows.push_back(config_row(CFG_SECOND_TAPS, 64'h80_8080_8080_8080));
        directed_rows.push_back(sample_row(16'sh7FFF, 1'b1, 1'b1, 38'sd0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CONFIG) begin
                if (i == 0 || directed_rows[i-1].kind != ROW_CONFIG) wait_for_drain();
                write_register(directed_rows[i].index, directed_rows[i].data);
            end else begin
                send_sample(directed_rows[i].sample, directed_rows[i].is_final,
                            directed_rows[i].has_typed, directed_rows[i].typed);
            end
        end

        // random phases, each with fresh taps and its own idling mix
        for (int phase = 0; phase < 3; phase++) begin
            wait_for_drain();
            send_idle_pct = sender_idle_by_phase[phase];
            recv_idle_pct = receiver_idle_by_phase[phase];
            write_register(CFG_FIRST_TAPS, {$urandom, $urandom});
            write_register(CFG_SECOND_TAPS, {$urandom, $urandom});
            if (phase == 2) stall_requests++;
            run_sequences(RANDOM_PER_PHASE, phase == 0);
        end

        wait_for_drain();
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
